>>> hdl/yaz_pkg.sv
// Shared types and constants for the Yaz-style LZ decompressor.
`timescale 1ns / 1ps
`default_nettype none

package yaz_pkg;

	localparam int HISTORY_DEPTH = 4096;
	localparam int DIST_W        = 12;
	localparam int COUNT_W       = 17;
	localparam int LEN_W         = 9;

	localparam logic [LEN_W-1:0] LONG_LEN_BIAS   = 9'h12;
	localparam logic [LEN_W-1:0] SHORT_LEN_BIAS  = 9'd2;
	localparam logic [3:0]       FLAGS_PER_GROUP = 4'd8;
	localparam logic [3:0]       LITERAL_COUNT   = 4'd1;
	localparam logic [3:0]       BAD_REF_COUNT   = 4'd0;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       start_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic        last_of_run;
		logic        stream_done;
		logic        bad_reference;
	} out_beat_t;

	typedef struct packed {
		logic clear;
		logic load_flags;
		logic literal;
		logic load_ref_hi;
		logic load_ref_lo;
		logic load_len;
		logic emit_bad;
		logic copy_go;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
		logic exp_zero;
		logic flag_bit;
		logic flags_last;
		logic flags_empty;
		logic long_code;
		logic bad_ref;
		logic copy_busy;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> hdl/yaz_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module yaz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/yaz_ctrl.sv
// Decode controller: tracks the token phase and sequences copies.
`timescale 1ns / 1ps
`default_nettype none

module yaz_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                start_of_stream,
	input  wire yaz_pkg::dp_status_t status,
	output logic                     in_stall,
	output yaz_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_FLAG,
		ST_ITEM,
		ST_REF2,
		ST_LEN,
		ST_START,
		ST_COPY,
		ST_HALT
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t eff_state;
	logic   open;
	logic   accept;
	logic   done_eff;

	always_comb begin
		open      = (state_q != ST_START) && (state_q != ST_COPY);
		in_stall  = !open || !status.out_free;
		accept    = in_valid && !in_stall;
		// a new stream restarts at the flag byte
		eff_state = start_of_stream ? ST_FLAG : state_q;
		done_eff  = start_of_stream ? status.exp_zero : status.done;
		cmd       = '0;
		state_d   = state_q;
		cmd.clear = accept && start_of_stream;

		unique case (state_q)
			ST_START: begin
				if (status.bad_ref) begin
					if (status.out_free) begin
						cmd.emit_bad = 1'b1;
						state_d      = ST_HALT;
					end
				end else begin
					cmd.copy_go = 1'b1;
					state_d     = ST_COPY;
				end
			end
			ST_COPY: begin
				if (!status.copy_busy) begin
					state_d = status.flags_empty ? ST_FLAG : ST_ITEM;
				end
			end
			default: begin
				if (accept) begin
					state_d = eff_state;
					unique case (eff_state)
						ST_FLAG: begin
							if (!done_eff) begin
								cmd.load_flags = 1'b1;
								state_d        = ST_ITEM;
							end
						end
						ST_ITEM: begin
							if (!done_eff) begin
								if (status.flag_bit) begin
									cmd.literal = 1'b1;
									state_d     = status.flags_last ? ST_FLAG : ST_ITEM;
								end else begin
									cmd.load_ref_hi = 1'b1;
									state_d         = ST_REF2;
								end
							end
						end
						ST_REF2: begin
							cmd.load_ref_lo = 1'b1;
							state_d         = status.long_code ? ST_LEN : ST_START;
						end
						ST_LEN: begin
							cmd.load_len = 1'b1;
							state_d      = ST_START;
						end
						default: begin
							// halted: byte dropped
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FLAG;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/yaz_dp.sv
// Decode datapath: token registers, history RAM, copy pipeline, output register.
`timescale 1ns / 1ps
`default_nettype none

module yaz_dp #(
	parameter int HISTORY_DEPTH = yaz_pkg::HISTORY_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire yaz_pkg::ctrl_cmd_t cmd,
	input  wire logic [7:0]         code_byte,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               out_stall,
	output yaz_pkg::dp_status_t     status,
	output logic                    out_valid,
	output yaz_pkg::out_beat_t      out_data
);

	localparam int AW      = $clog2(HISTORY_DEPTH);
	localparam int COUNT_W = yaz_pkg::COUNT_W;
	localparam int DIST_W  = yaz_pkg::DIST_W;
	localparam int LEN_W   = yaz_pkg::LEN_W;

	logic [COUNT_W-1:0] prod_q;
	logic [15:0]        exp_q;
	logic [7:0]         flag_q;
	logic [3:0]         frem_q;
	logic [15:0]        ref_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   iss_left_q;
	logic               first_q;
	logic               valid_s2;
	logic [2:0]         fill_q;
	logic [55:0]        grp_q;
	logic               out_valid_q;

	logic [AW-1:0]      rd_addr_q;
	logic               fwd_s2;
	logic               last_s2;
	logic [7:0]         last_byte_q;
	yaz_pkg::out_beat_t out_q;

	logic               out_free;
	logic               closes;
	logic               hold;
	logic               adv;
	logic               issue;
	logic               step;
	logic [7:0]         ram_rdata;
	logic [7:0]         copy_byte;
	logic               ram_we;
	logic [7:0]         ram_wdata;
	logic [63:0]        grp_bytes;
	logic [COUNT_W-1:0] prod_inc;
	logic [COUNT_W-1:0] exp_ext;
	logic [DIST_W:0]    back;

	always_comb begin
		out_free  = !out_valid_q || !out_stall;
		closes    = (fill_q == 3'd7) || last_s2;
		hold      = valid_s2 && closes && !out_free;
		adv       = !hold;
		issue     = (iss_left_q != '0) && adv;
		step      = valid_s2 && adv;
		// distance one: the source byte is the one written just before
		copy_byte = fwd_s2 ? last_byte_q : ram_rdata;
		ram_we    = cmd.literal || step;
		ram_wdata = cmd.literal ? code_byte : copy_byte;
		prod_inc  = prod_q + COUNT_W'(1);
		exp_ext   = COUNT_W'(exp_q);
		back      = {1'b0, ref_q[DIST_W-1:0]} + (DIST_W+1)'(1);

		grp_bytes = {8'h00, grp_q};
		for (int i = 0; i < 8; i++) begin
			if (3'(i) == fill_q) begin
				grp_bytes[8*i +: 8] = copy_byte;
			end
		end

		status.done        = prod_q >= exp_ext;
		status.exp_zero    = (exp_q == '0);
		status.flag_bit    = flag_q[7];
		status.flags_last  = (frem_q == 4'd1);
		status.flags_empty = (frem_q == 4'd0);
		status.long_code   = (ref_q[15:12] == 4'd0);
		status.bad_ref     = COUNT_W'(back) > prod_q;
		status.copy_busy   = (iss_left_q != '0) || valid_s2;
		status.out_free    = out_free;
	end

	yaz_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (ram_we),
		.waddr(prod_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q      <= '0;
			exp_q       <= '0;
			flag_q      <= '0;
			frem_q      <= '0;
			ref_q       <= '0;
			len_q       <= '0;
			iss_left_q  <= '0;
			first_q     <= 1'b0;
			valid_s2    <= 1'b0;
			fill_q      <= '0;
			grp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				exp_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				prod_q <= '0;
				flag_q <= '0;
				frem_q <= '0;
				ref_q  <= '0;
			end
			if (cmd.load_flags) begin
				flag_q <= code_byte;
				frem_q <= yaz_pkg::FLAGS_PER_GROUP;
			end
			if (cmd.literal || cmd.emit_bad || cmd.copy_go) begin
				flag_q <= {flag_q[6:0], 1'b0};
				frem_q <= frem_q - 4'd1;
			end
			if (cmd.literal || step) begin
				prod_q <= prod_inc;
			end
			if (cmd.load_ref_hi) begin
				ref_q[15:8] <= code_byte;
			end
			if (cmd.load_ref_lo) begin
				ref_q[7:0] <= code_byte;
				len_q      <= LEN_W'(ref_q[15:12]) + yaz_pkg::SHORT_LEN_BIAS;
			end
			if (cmd.load_len) begin
				len_q <= LEN_W'(code_byte) + yaz_pkg::LONG_LEN_BIAS;
			end
			if (cmd.copy_go) begin
				iss_left_q <= len_q;
				first_q    <= 1'b1;
			end else if (issue) begin
				iss_left_q <= iss_left_q - LEN_W'(1);
				first_q    <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= issue;
			end
			if (step) begin
				fill_q <= closes ? 3'd0 : fill_q + 3'd1;
				grp_q  <= closes ? 56'd0 : grp_bytes[55:0];
			end
			if (cmd.literal || cmd.emit_bad || (step && closes)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_go) begin
			rd_addr_q <= prod_q[AW-1:0] - AW'(ref_q[DIST_W-1:0]) - AW'(1);
		end else if (issue) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (issue) begin
			fwd_s2  <= (ref_q[DIST_W-1:0] == '0) && !first_q;
			last_s2 <= (iss_left_q == LEN_W'(1));
		end
		if (step) begin
			last_byte_q <= copy_byte;
		end
		if (cmd.literal) begin
			out_q.out_bytes     <= 64'(code_byte);
			out_q.byte_count    <= yaz_pkg::LITERAL_COUNT;
			out_q.last_of_run   <= 1'b1;
			out_q.stream_done   <= prod_inc >= exp_ext;
			out_q.bad_reference <= 1'b0;
		end else if (cmd.emit_bad) begin
			out_q.out_bytes     <= '0;
			out_q.byte_count    <= yaz_pkg::BAD_REF_COUNT;
			out_q.last_of_run   <= 1'b1;
			out_q.stream_done   <= prod_q >= exp_ext;
			out_q.bad_reference <= 1'b1;
		end else if (step && closes) begin
			out_q.out_bytes     <= grp_bytes;
			out_q.byte_count    <= {1'b0, fill_q} + 4'd1;
			out_q.last_of_run   <= last_s2;
			out_q.stream_done   <= prod_inc >= exp_ext;
			out_q.bad_reference <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> hdl/yaz_lz_decompressor.sv
// Top level of the Yaz-style LZ decompressor: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// Takes one compressed byte per beat and returns decompressed bytes in beats of up
// to eight (first byte in bits 7..0). Flag bytes and the first bytes of a back
// reference give no beat; a literal gives a one-byte beat. A back reference of length
// L (3..273) holds the input after its last byte while the distance is checked, then
// while one byte per cycle is copied (unless a stalled output beat holds the copy)
// through the single read port of the 4096-byte history RAM, whose read data is
// registered, and while control hands back to token decode. Full eight-byte beats go
// out during the copy, the remainder as the final beat of the run (last_of_run).
// A stalled output beat holds the copy and the input. Once the produced count
// reaches expected_length, new tokens are dropped until start_of_stream; a copy
// already under way finishes whole. A distance reaching before the first byte of the
// stream gives one beat with byte_count 0 and bad_reference set, and the block then
// drops every byte until start_of_stream. expected_length is written on cfg_we and
// must only change while the block is idle.
module yaz_lz_decompressor #(
	parameter int HISTORY_DEPTH = yaz_pkg::HISTORY_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// compressed byte channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire yaz_pkg::in_beat_t in_data,
	// decompressed beat channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output yaz_pkg::out_beat_t     out_data,
	// expected_length register
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_wdata
);

	yaz_pkg::ctrl_cmd_t  cmd;
	yaz_pkg::dp_status_t status;

	// token phase, copy start and halt sequencing
	yaz_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.start_of_stream(in_data.start_of_stream),
		.status         (status),
		.in_stall       (in_stall),
		.cmd            (cmd)
	);

	// flag/reference registers, byte count, history and output register
	yaz_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.code_byte(in_data.code_byte),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_stall(out_stall),
		.status   (status),
		.out_valid(out_valid),
		.out_data (out_data)
	);

	// input must be held off while a copy is still running
	a_copy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		status.copy_busy |-> in_stall)
		else $error("input open during copy");

	// only the final beat of a run may be partial
	a_partial_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last_of_run) |-> (out_data.byte_count == 4'd8))
		else $error("partial beat before end of run");

	// a taken bad-reference beat is not followed by another beat right away
	a_halt_after_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.bad_reference) |=> !out_valid)
		else $error("beat right after bad reference");

	// data beats always carry bytes
	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.bad_reference) |->
			(out_data.byte_count != 4'd0 && out_data.byte_count <= 4'd8))
		else $error("bad byte count");

endmodule

`default_nettype wire
